### hdl/dqs_pkg.sv
// Package for the deque with search.
// Holds the operation and status codes and the transaction structs.
// No dependencies.
package dqs_pkg;

  localparam int unsigned OP_W  = 3;
  localparam int unsigned VAL_W = 32;
  localparam int unsigned ST_W  = 2;
  localparam int unsigned POS_W = 4;

  localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
  localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd1;
  localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
  localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd3;
  localparam logic [OP_W-1:0] OP_SEARCH     = 3'd4;

  localparam logic [ST_W-1:0] ST_DONE  = 2'd0;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd1;
  localparam logic [ST_W-1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic [OP_W-1:0]         operation;
    logic signed [VAL_W-1:0] value;
  } in_t;

  typedef struct packed {
    logic [ST_W-1:0]  status;
    logic             found;
    logic [POS_W-1:0] position;
  } out_t;

endpackage

### hdl/deque_with_search.sv
// Bounded double-ended queue of 32-bit words with a linear search.
// Depends on dqs_pkg (codes and transaction structs).
//
// A transaction is taken when start is high and busy is low. Pushes, pops
// and unused operation codes finish without a scan: their result strobes on
// out_strobe in the cycle after the transaction, and busy stays low, so a
// new transaction may follow at once. A search reads the word memory one
// entry per cycle from the front; busy stays high until the first match or
// the last stored entry, and the result strobes as busy drops. A search of
// an empty queue keeps busy low and its result strobes in the cycle after
// the transaction. Each result is shown for exactly one cycle and cannot be
// held off by the receiver.
module deque_with_search #(
  parameter int unsigned DEPTH = 16
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  input  dqs_pkg::in_t   in_data,
  output logic           out_strobe,
  output dqs_pkg::out_t  out_data
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_SCAN = 1'b1;

  logic                        state_r, state_nxt;
  logic [PW-1:0]               head_r, head_nxt;
  logic [CW-1:0]               occ_r, occ_nxt;
  logic [PW-1:0]               scan_ptr_r, scan_ptr_nxt;
  logic [PW-1:0]               idx_r, idx_nxt;
  logic [dqs_pkg::VAL_W-1:0]   key_r;
  logic [dqs_pkg::VAL_W-1:0]   rd_data_r;
  logic                        strobe_r, strobe_nxt;
  dqs_pkg::out_t               res_r, res_nxt;

  logic [dqs_pkg::VAL_W-1:0]   mem [DEPTH];

  logic                        accept;
  logic                        full, empty;
  logic                        wr_en;
  logic [PW-1:0]               wr_addr;
  logic                        rd_en;
  logic [PW-1:0]               rd_addr;
  logic [PW-1:0]               head_dec, head_inc, tail;
  logic [PW:0]                 tail_sum, inc_sum, scan_sum;
  logic [CW-1:0]               idx_next_cnt;

  assign accept = start && (state_r == ST_IDLE);
  assign full   = (occ_r == CW'(DEPTH));
  assign empty  = (occ_r == '0);

  assign head_dec = (head_r == '0) ? PW'(DEPTH - 1) : head_r - PW'(1);
  assign inc_sum  = {1'b0, head_r} + (PW+1)'(1);
  assign head_inc = (inc_sum >= (PW+1)'(DEPTH)) ? PW'(inc_sum - (PW+1)'(DEPTH))
                                                : inc_sum[PW-1:0];
  assign tail_sum = {1'b0, head_r} + {1'b0, occ_r[PW-1:0]};
  assign tail     = (tail_sum >= (PW+1)'(DEPTH)) ? PW'(tail_sum - (PW+1)'(DEPTH))
                                                 : tail_sum[PW-1:0];
  assign scan_sum = {1'b0, scan_ptr_r} + (PW+1)'(1);
  assign idx_next_cnt = CW'(idx_r) + CW'(1);

  always_comb begin
    state_nxt    = state_r;
    head_nxt     = head_r;
    occ_nxt      = occ_r;
    scan_ptr_nxt = scan_ptr_r;
    idx_nxt      = idx_r;
    strobe_nxt   = 1'b0;
    res_nxt      = res_r;
    wr_en        = 1'b0;
    wr_addr      = tail;
    rd_en        = 1'b0;
    rd_addr      = head_r;

    if (state_r == ST_IDLE) begin
      if (accept) begin
        strobe_nxt = 1'b1;
        res_nxt    = '{status: dqs_pkg::ST_DONE, found: 1'b0, position: '0};
        case (in_data.operation)
          dqs_pkg::OP_PUSH_FRONT: begin
            if (full) begin
              res_nxt.status = dqs_pkg::ST_FULL;
            end else begin
              wr_en    = 1'b1;
              wr_addr  = head_dec;
              head_nxt = head_dec;
              occ_nxt  = occ_r + CW'(1);
            end
          end
          dqs_pkg::OP_PUSH_BACK: begin
            if (full) begin
              res_nxt.status = dqs_pkg::ST_FULL;
            end else begin
              wr_en   = 1'b1;
              wr_addr = tail;
              occ_nxt = occ_r + CW'(1);
            end
          end
          dqs_pkg::OP_POP_FRONT: begin
            if (empty) begin
              res_nxt.status = dqs_pkg::ST_EMPTY;
            end else begin
              head_nxt = head_inc;
              occ_nxt  = occ_r - CW'(1);
            end
          end
          dqs_pkg::OP_POP_BACK: begin
            if (empty) begin
              res_nxt.status = dqs_pkg::ST_EMPTY;
            end else begin
              occ_nxt = occ_r - CW'(1);
            end
          end
          dqs_pkg::OP_SEARCH: begin
            if (empty) begin
              res_nxt.status = dqs_pkg::ST_EMPTY;
            end else begin
              strobe_nxt   = 1'b0;
              rd_en        = 1'b1;
              rd_addr      = head_r;
              scan_ptr_nxt = head_r;
              idx_nxt      = '0;
              state_nxt    = ST_SCAN;
            end
          end
          default: ;
        endcase
      end
    end else begin
      // rd_data_r holds the entry at index idx_r
      if (rd_data_r == key_r) begin
        strobe_nxt = 1'b1;
        res_nxt    = '{status: dqs_pkg::ST_DONE, found: 1'b1,
                       position: dqs_pkg::POS_W'(idx_r)};
        state_nxt  = ST_IDLE;
      end else if (idx_next_cnt == occ_r) begin
        strobe_nxt = 1'b1;
        res_nxt    = '{status: dqs_pkg::ST_EMPTY, found: 1'b0, position: '0};
        state_nxt  = ST_IDLE;
      end else begin
        scan_ptr_nxt = (scan_sum >= (PW+1)'(DEPTH)) ? PW'(scan_sum - (PW+1)'(DEPTH))
                                                    : scan_sum[PW-1:0];
        rd_en        = 1'b1;
        rd_addr      = scan_ptr_nxt;
        idx_nxt      = idx_r + PW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= in_data.value;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      head_r   <= '0;
      occ_r    <= '0;
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      head_r   <= head_nxt;
      occ_r    <= occ_nxt;
      strobe_r <= strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    scan_ptr_r <= scan_ptr_nxt;
    idx_r      <= idx_nxt;
    res_r      <= res_nxt;
    if (accept) begin
      key_r <= in_data.value;
    end
  end

  assign busy       = (state_r == ST_SCAN);
  assign out_strobe = strobe_r;
  assign out_data   = res_r;

endmodule

### hdl/dqs_chk.sv
// Port-level checker for the deque with search, bound to the top level.
// Depends on dqs_pkg and deque_with_search.
module dqs_chk (
  input logic          clk,
  input logic          rst_n,
  input logic          start,
  input logic          busy,
  input dqs_pkg::in_t  in_data,
  input logic          out_strobe,
  input dqs_pkg::out_t out_data
);

  a_quick_op: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_data.operation != dqs_pkg::OP_SEARCH) |=> (out_strobe && !busy))
    else $error("push/pop transaction gave no result next cycle");

  a_scan_end: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_strobe)
    else $error("search ended without a result");

  a_found_done: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_data.found) |-> (out_data.status == dqs_pkg::ST_DONE))
    else $error("match reported with bad status");

  a_pos_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && !out_data.found) |-> (out_data.position == '0))
    else $error("nonzero position without a match");

  a_no_orphan: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> ($past(busy) || $past(start)))
    else $error("result without a transaction");

endmodule

bind deque_with_search dqs_chk u_dqs_chk (.*);
